// ===== rtl/ttw_pkg.sv =====
// Shared types and constants for the text terminal writer.
// Holds the channel payload structs, the command codes passed from the
// front end to the executor, and the character and register codes.
package ttw_pkg;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] char_code;
    logic [4:0] row;
    logic [6:0] col;
  } in_t;

  typedef struct packed {
    logic [4:0]  pos_row;
    logic [6:0]  pos_col;
    logic [10:0] cursor_pos;
    logic [7:0]  read_char;
    logic [7:0]  read_attr;
    logic        scrolled;
  } out_t;

  // Request types on the input channel
  localparam logic [1:0] REQ_PUT    = 2'd0;
  localparam logic [1:0] REQ_READ   = 2'd1;
  localparam logic [1:0] REQ_SETCUR = 2'd2;
  localparam logic [1:0] REQ_CLEAR  = 2'd3;

  // Decoded command codes
  localparam logic [2:0] OP_PUT    = 3'd0;
  localparam logic [2:0] OP_NL     = 3'd1;
  localparam logic [2:0] OP_CR     = 3'd2;
  localparam logic [2:0] OP_BS     = 3'd3;
  localparam logic [2:0] OP_TAB    = 3'd4;
  localparam logic [2:0] OP_READ   = 3'd5;
  localparam logic [2:0] OP_SETCUR = 3'd6;
  localparam logic [2:0] OP_CLEAR  = 3'd7;

  // Control characters
  localparam logic [7:0] CH_BS = 8'h08;
  localparam logic [7:0] CH_HT = 8'h09;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  localparam logic [7:0] BLANK_CH     = 8'h20;
  localparam logic [7:0] DEFAULT_ATTR = 8'h07;
  localparam logic [7:0] TAB_MASK     = 8'hF8;
  localparam logic [7:0] TAB_STEP     = 8'd8;

  // Configuration register indexes
  localparam logic REG_FORE = 1'b0;
  localparam logic REG_BACK = 1'b1;

  // Command queued between front end and executor
  typedef struct packed {
    logic [2:0] op;
    logic [7:0] ch;
    logic [4:0] row;   // saturated to the screen
    logic [6:0] col;   // saturated to the screen
    logic       oob;   // requested cell lies off the screen
  } cmd_t;

endpackage

// ===== rtl/text_terminal_writer_unit.sv =====
// Top level of the text terminal writer: colour registers, front end
// and executor. Depends on ttw_pkg, ttw_front, ttw_back (and ttw_ram).
//
//   Port group   Direction  Handshake        Payload
//   in_          in         in_valid/ready   in_t  (req_type, char_code, row, col)
//   out_         out        out_valid/ready  out_t (cursor, pos, read cell, scrolled)
//   cfg_         in         cfg_we only      cfg_index, cfg_wdata (4-bit colour)
//
// Put, read and set-cursor requests pass through the executor's issue and done states.
// A scroll adds a copy pass (one cell copied per cycle over the
// single-write buffer port); a clear adds a blanking pass over every cell.
// After reset the buffer is blanked with in_ready low.
// A two-entry command queue lets requests enter while the executor works;
// a stalled result holds in the output register and blocks the next issue.
module text_terminal_writer_unit import ttw_pkg::*; #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_t       out_data,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [3:0] cfg_wdata
);

  logic [3:0] fore_r;
  logic [3:0] back_r;
  logic       enable;
  logic       q_valid;
  logic       q_pop;
  cmd_t       q_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fore_r <= 4'd7;
      back_r <= 4'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FORE: fore_r <= cfg_wdata;
        REG_BACK: back_r <= cfg_wdata;
        default:  fore_r <= fore_r;
      endcase
    end
  end

  ttw_front #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .enable  (enable),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data (in_data),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop)
  );

  ttw_back #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .attr           ({back_r, fore_r}),
    .ready_for_input(enable),
    .q_valid        (q_valid),
    .q_cmd          (q_cmd),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data)
  );

endmodule

// ===== rtl/ttw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependencies.
module ttw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/ttw_front.sv =====
// Front end: accepts requests, decodes them into commands and queues them.
// Depends on ttw_pkg for the payload and command types.
module ttw_front import ttw_pkg::*; #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic clk,
  input  logic rst_n,
  input  logic enable,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic q_valid,
  output cmd_t q_cmd,
  input  logic q_pop
);

  cmd_t       cmd;
  cmd_t       slot_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic       push;
  logic       row_oob;
  logic       col_oob;

  always_comb begin
    row_oob   = {1'b0, in_data.row} >= 6'(ROWS);
    col_oob   = {1'b0, in_data.col} >= 8'(COLS);
    cmd.ch    = in_data.char_code;
    cmd.row   = row_oob ? 5'(ROWS - 1) : in_data.row;
    cmd.col   = col_oob ? 7'(COLS - 1) : in_data.col;
    cmd.oob   = row_oob || col_oob;
    case (in_data.req_type)
      REQ_PUT: begin
        case (in_data.char_code)
          CH_LF:   cmd.op = OP_NL;
          CH_CR:   cmd.op = OP_CR;
          CH_BS:   cmd.op = OP_BS;
          CH_HT:   cmd.op = OP_TAB;
          default: cmd.op = OP_PUT;
        endcase
      end
      REQ_READ:   cmd.op = OP_READ;
      REQ_SETCUR: cmd.op = OP_SETCUR;
      default:    cmd.op = OP_CLEAR;
    endcase
  end

  assign in_ready = enable && (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = cnt_r != 2'd0;
  assign q_cmd    = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (q_pop) begin
        rp_r <= ~rp_r;
      end
      case ({push, q_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= cmd;
    end
  end

endmodule

// ===== rtl/ttw_back.sv =====
// Executor: cursor state, cell buffer sequencing (init, clear, scroll)
// and the result register. Depends on ttw_pkg and instantiates ttw_ram.
module ttw_back import ttw_pkg::*; #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] attr,
  output logic       ready_for_input,
  input  logic       q_valid,
  input  cmd_t       q_cmd,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output out_t       out_data
);

  localparam int CELLS = ROWS * COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(CELLS + 1);
  localparam int MW    = (AW > 11) ? AW : 11;

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_FILL   = 3'd2;
  localparam logic [2:0] S_SCROLL = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [4:0]    cur_row_r, cur_row_nxt;
  logic [6:0]    cur_col_r, cur_col_nxt;
  logic          scr_r, scr_nxt;
  logic          rd_op_r, rd_op_nxt;
  logic          oob_r, oob_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_t          out_data_r, out_data_nxt;

  logic          out_free;
  logic          start;
  logic [5:0]    row_inc;
  logic [7:0]    col_inc;
  logic [7:0]    tab_nxt;
  logic [6:0]    col_dec;
  logic [5:0]    nrow;
  logic [6:0]    ncol;
  logic          wrap;
  logic [4:0]    mrow;
  logic [6:0]    mcol;
  logic [MW-1:0] mul;
  logic [CW-1:0] cnt_m1;
  logic [15:0]   blank;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [15:0]   ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [15:0]   ram_rdata;

  ttw_ram #(
    .WIDTH(16),
    .DEPTH(CELLS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign out_free        = !out_valid_r || out_ready;
  assign start           = (state_r == S_IDLE) && q_valid && out_free;
  assign q_pop           = start;
  assign ready_for_input = state_r != S_INIT;
  assign blank           = {attr, BLANK_CH};
  assign cnt_m1          = cnt_r - CW'(1);

  // Next cursor for the command at the head of the queue
  always_comb begin
    row_inc = {1'b0, cur_row_r} + 6'd1;
    col_inc = {1'b0, cur_col_r} + 8'd1;
    tab_nxt = ({1'b0, cur_col_r} + TAB_STEP) & TAB_MASK;
    col_dec = (cur_col_r == 7'd0) ? 7'd0 : cur_col_r - 7'd1;
    nrow    = {1'b0, cur_row_r};
    ncol    = cur_col_r;
    case (q_cmd.op)
      OP_NL: begin
        ncol = 7'd0;
        nrow = row_inc;
      end
      OP_CR: ncol = 7'd0;
      OP_BS: ncol = col_dec;
      OP_TAB: begin
        if (tab_nxt >= 8'(COLS)) begin
          ncol = 7'd0;
          nrow = row_inc;
        end else begin
          ncol = tab_nxt[6:0];
        end
      end
      OP_PUT: begin
        if (col_inc >= 8'(COLS)) begin
          ncol = 7'd0;
          nrow = row_inc;
        end else begin
          ncol = col_inc[6:0];
        end
      end
      OP_SETCUR: begin
        nrow = {1'b0, q_cmd.row};
        ncol = q_cmd.col;
      end
      OP_CLEAR: begin
        nrow = 6'd0;
        ncol = 7'd0;
      end
      default: begin
        nrow = {1'b0, cur_row_r};
        ncol = cur_col_r;
      end
    endcase
    wrap = nrow == 6'(ROWS);
  end

  // One shared row * COLS + col unit: cell address on issue, cursor_pos on done
  always_comb begin
    if (state_r == S_DONE) begin
      mrow = cur_row_r;
      mcol = cur_col_r;
    end else if (q_cmd.op == OP_READ) begin
      mrow = q_cmd.row;
      mcol = q_cmd.col;
    end else if (q_cmd.op == OP_BS) begin
      mrow = cur_row_r;
      mcol = col_dec;
    end else begin
      mrow = cur_row_r;
      mcol = cur_col_r;
    end
    mul = MW'(mrow) * MW'(COLS) + MW'(mcol);
  end

  // Buffer port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_r[AW-1:0];
    ram_wdata = blank;
    ram_re    = 1'b0;
    ram_raddr = mul[AW-1:0];
    case (state_r)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = {DEFAULT_ATTR, BLANK_CH};
      end
      S_FILL: ram_we = 1'b1;
      S_IDLE: begin
        ram_waddr = mul[AW-1:0];
        if (start && q_cmd.op == OP_PUT) begin
          ram_we    = 1'b1;
          ram_wdata = {attr, q_cmd.ch};
        end else if (start && q_cmd.op == OP_BS) begin
          ram_we = 1'b1;
        end
        ram_re = start && (q_cmd.op == OP_READ) && !q_cmd.oob;
      end
      S_SCROLL: begin
        // read one row ahead, write the word read last cycle one row up
        ram_re    = cnt_r < CW'(CELLS - COLS);
        ram_raddr = AW'(cnt_r + CW'(COLS));
        ram_we    = cnt_r != CW'(0);
        ram_waddr = cnt_m1[AW-1:0];
        ram_wdata = (cnt_m1 < CW'(CELLS - COLS)) ? ram_rdata : blank;
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cur_row_nxt   = cur_row_r;
    cur_col_nxt   = cur_col_r;
    scr_nxt       = scr_r;
    rd_op_nxt     = rd_op_r;
    oob_nxt       = oob_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    case (state_r)
      S_INIT: begin
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(CELLS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cur_row_nxt = wrap ? 5'(ROWS - 1) : nrow[4:0];
          cur_col_nxt = ncol;
          scr_nxt     = wrap;
          rd_op_nxt   = q_cmd.op == OP_READ;
          oob_nxt     = q_cmd.oob;
          cnt_nxt     = '0;
          if (q_cmd.op == OP_CLEAR) begin
            state_nxt = S_FILL;
          end else if (wrap) begin
            state_nxt = S_SCROLL;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_FILL: begin
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(CELLS - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_SCROLL: begin
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(CELLS)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        out_valid_nxt           = 1'b1;
        out_data_nxt.pos_row    = cur_row_r;
        out_data_nxt.pos_col    = cur_col_r;
        out_data_nxt.cursor_pos = mul[10:0];
        out_data_nxt.scrolled   = scr_r;
        if (!rd_op_r) begin
          out_data_nxt.read_char = 8'd0;
          out_data_nxt.read_attr = 8'd0;
        end else if (oob_r) begin
          out_data_nxt.read_char = BLANK_CH;
          out_data_nxt.read_attr = DEFAULT_ATTR;
        end else begin
          out_data_nxt.read_char = ram_rdata[7:0];
          out_data_nxt.read_attr = ram_rdata[15:8];
        end
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      cnt_r       <= '0;
      cur_row_r   <= 5'd0;
      cur_col_r   <= 7'd0;
      scr_r       <= 1'b0;
      rd_op_r     <= 1'b0;
      oob_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
      scr_r       <= scr_nxt;
      rd_op_r     <= rd_op_nxt;
      oob_r       <= oob_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== dv/text_terminal_writer_unit_test.sv =====
// Testbench for text_terminal_writer_unit: directed requests, then random mixes of
// put, read, cursor and clear requests; all but the typed directed rows are checked
// against a cycle-free screen model. Depends on ttw_pkg and the RTL top level only.
`timescale 1ns / 1ps

module text_terminal_writer_unit_test;
  import ttw_pkg::*;

  localparam int ROWS = 25;
  localparam int COLS = 80;
  localparam int CELLS = ROWS * COLS;
  localparam int SEG_ITEMS = 320;
  localparam int N_SEGS = 6;
  localparam int SETTLE = 8;
  localparam int MAX_GAP = 64;
  // every request a full-buffer walk plus both sides' longest gaps, taken four times over
  localparam int LIMIT = 4 * (CELLS + (N_SEGS * SEG_ITEMS + 30) * (CELLS + 4 + 2 * MAX_GAP));

  typedef struct packed {
    logic typed;
    in_t  req;
    out_t want;
  } step_t;

  localparam out_t NO_RESULT = '0;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_FORE;
  logic [3:0] cfg_wdata = 4'd0;

  // screen model
  logic [15:0] screen [CELLS];
  int crow, ccol;
  logic [3:0] fg, bg;

  out_t  pending_replies[$];
  step_t dir_tab[$];
  int errors = 0;
  int cycle_count = 0;
  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int n_items = 0, n_replies = 0, n_scrolls = 0, n_clears = 0, n_oob = 0;

  text_terminal_writer_unit #(.ROWS(ROWS), .COLS(COLS)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Apply one request to the screen model and return the reply it should produce.
  function automatic out_t apply_request(in_t x);
    out_t o;
    logic [7:0] attr;
    int idx, nxt, i;
    o = '0;
    attr = {bg, fg};
    case (x.req_type)
      REQ_PUT: begin
        case (x.char_code)
          CH_LF: begin
            ccol = 0;
            crow++;
          end
          CH_CR: ccol = 0;
          CH_BS: begin
            if (ccol != 0) ccol--;
            idx = crow * COLS + ccol;
            if (idx < CELLS) screen[idx] = {attr, BLANK_CH};
          end
          CH_HT: begin
            nxt = (ccol + 8) & ~7;
            if (nxt >= COLS) begin
              ccol = 0;
              crow++;
            end else begin
              ccol = nxt;
            end
          end
          default: begin
            idx = crow * COLS + ccol;
            if (idx < CELLS) screen[idx] = {attr, x.char_code};
            ccol++;
            if (ccol >= COLS) begin
              ccol = 0;
              crow++;
            end
          end
        endcase
        if (crow >= ROWS) begin
          for (i = 0; i + COLS < CELLS; i++) screen[i] = screen[i + COLS];
          for (i = (ROWS - 1) * COLS; i < CELLS; i++) screen[i] = {attr, BLANK_CH};
          crow = ROWS - 1;
          o.scrolled = 1'b1;
          n_scrolls++;
        end
      end
      REQ_READ: begin
        if (x.row >= ROWS || x.col >= COLS) begin
          o.read_char = BLANK_CH;
          o.read_attr = DEFAULT_ATTR;
          n_oob++;
        end else begin
          {o.read_attr, o.read_char} = screen[x.row * COLS + x.col];
        end
      end
      REQ_SETCUR: begin
        crow = (x.row >= ROWS) ? ROWS - 1 : int'(x.row);
        ccol = (x.col >= COLS) ? COLS - 1 : int'(x.col);
      end
      default: begin
        // clear screen
        for (i = 0; i < CELLS; i++) screen[i] = {attr, BLANK_CH};
        crow = 0;
        ccol = 0;
        n_clears++;
      end
    endcase
    o.pos_row = crow[4:0];
    o.pos_col = ccol[6:0];
    o.cursor_pos = 11'(crow * COLS + ccol);
    return o;
  endfunction

  function automatic in_t rand_request();
    in_t x;
    int pick, k;
    x.req_type = REQ_PUT;
    x.char_code = 8'($urandom_range(255));
    x.row = 5'($urandom_range(31));
    x.col = 7'($urandom_range(127));
    pick = $urandom_range(99);
    if (pick < 68) begin
      k = $urandom_range(99);
      if (k < 6) x.char_code = CH_LF;
      else if (k < 11) x.char_code = CH_CR;
      else if (k < 18) x.char_code = CH_BS;
      else if (k < 26) x.char_code = CH_HT;
    end else if (pick < 83) begin
      x.req_type = REQ_READ;
      if ($urandom_range(9) < 7) begin
        x.row = 5'($urandom_range(ROWS - 1));
        x.col = 7'($urandom_range(COLS - 1));
      end
    end else if (pick < 98) begin
      x.req_type = REQ_SETCUR;
    end else begin
      x.req_type = REQ_CLEAR;
    end
    return x;
  endfunction

  // Hold the transfer until accepted, then log the reply it should produce.
  task automatic send_item(in_t x, logic typed, out_t want);
    out_t o;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= x;
    do @(posedge clk); while (!in_ready);
    o = apply_request(x);
    pending_replies.push_back(typed ? want : o);
    n_items++;
  endtask

  task automatic wait_for_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_colours(logic [3:0] f, logic [3:0] b);
    cfg_we <= 1'b1;
    cfg_index <= REG_FORE;
    cfg_wdata <= f;
    @(posedge clk);
    cfg_index <= REG_BACK;
    cfg_wdata <= b;
    @(posedge clk);
    cfg_we <= 1'b0;
    fg = f;
    bg = b;
  endtask

  task automatic check_field(string fname, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, want, got);
    end
  endtask

  always @(posedge clk) begin : watch_replies
    out_t want;
    out_ready <= ($urandom_range(99) >= out_idle_pct);
    if (rst_n && out_valid && out_ready) begin
      n_replies++;
      if (pending_replies.size() == 0) begin
        errors++;
        $display("%0t: unexpected reply %h", $time, out_data);
      end else begin
        want = pending_replies.pop_front();
        check_field("pos_row", want.pos_row, out_data.pos_row);
        check_field("pos_col", want.pos_col, out_data.pos_col);
        check_field("cursor_pos", want.cursor_pos, out_data.cursor_pos);
        check_field("read_char", want.read_char, out_data.read_char);
        check_field("read_attr", want.read_attr, out_data.read_attr);
        check_field("scrolled", want.scrolled, out_data.scrolled);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int s, n;
    for (n = 0; n < CELLS; n++) screen[n] = {DEFAULT_ATTR, BLANK_CH};
    crow = 0;
    ccol = 0;
    fg = 4'd7;
    bg = 4'd0;

    // typed rows: fresh screen, out-of-range reads, saturated cursor, clear
    dir_tab.push_back({1'b1, REQ_READ, 8'h00, 5'd0, 7'd0,
                       5'd0, 7'd0, 11'd0, BLANK_CH, DEFAULT_ATTR, 1'b0});
    dir_tab.push_back({1'b1, REQ_READ, 8'hFF, 5'd31, 7'd127,
                       5'd0, 7'd0, 11'd0, BLANK_CH, DEFAULT_ATTR, 1'b0});
    dir_tab.push_back({1'b0, REQ_PUT, 8'h41, 5'd0, 7'd0, NO_RESULT});
    dir_tab.push_back({1'b0, REQ_PUT, 8'h00, 5'd31, 7'd127, NO_RESULT});
    dir_tab.push_back({1'b0, REQ_PUT, 8'hFF, 5'd0, 7'd0, NO_RESULT});
    dir_tab.push_back({1'b0, REQ_PUT, CH_BS, 5'd0, 7'd0, NO_RESULT});
    dir_tab.push_back({1'b0, REQ_PUT, CH_HT, 5'd0, 7'd0, NO_RESULT});
    dir_tab.push_back({1'b0, REQ_PUT, CH_CR, 5'd0, 7'd0, NO_RESULT});
    dir_tab.push_back({1'b0, REQ_PUT, CH_LF, 5'd0, 7'd0, NO_RESULT});
    dir_tab.push_back({1'b0, REQ_READ, 8'h00, 5'd0, 7'd0, NO_RESULT});
    dir_tab.push_back({1'b1, REQ_SETCUR, 8'h00, 5'd31, 7'd127,
                       5'd24, 7'd79, 11'd1999, 8'h00, 8'h00, 1'b0});
    // last cell: write, wrap and scroll
    dir_tab.push_back({1'b0, REQ_PUT, 8'h5A, 5'd0, 7'd0, NO_RESULT});
    dir_tab.push_back({1'b0, REQ_READ, 8'h00, 5'd23, 7'd79, NO_RESULT});
    dir_tab.push_back({1'b1, REQ_SETCUR, 8'h00, 5'd24, 7'd76,
                       5'd24, 7'd76, 11'd1996, 8'h00, 8'h00, 1'b0});
    dir_tab.push_back({1'b0, REQ_PUT, CH_HT, 5'd0, 7'd0, NO_RESULT});
    dir_tab.push_back({1'b0, REQ_PUT, CH_LF, 5'd0, 7'd0, NO_RESULT});
    dir_tab.push_back({1'b1, REQ_SETCUR, 8'h00, 5'd0, 7'd0,
                       5'd0, 7'd0, 11'd0, 8'h00, 8'h00, 1'b0});
    dir_tab.push_back({1'b0, REQ_PUT, CH_BS, 5'd0, 7'd0, NO_RESULT});
    dir_tab.push_back({1'b1, REQ_SETCUR, 8'h00, 5'd0, 7'd79,
                       5'd0, 7'd79, 11'd79, 8'h00, 8'h00, 1'b0});
    dir_tab.push_back({1'b0, REQ_PUT, CH_HT, 5'd0, 7'd0, NO_RESULT});
    dir_tab.push_back({1'b0, REQ_READ, 8'h00, 5'd0, 7'd80, NO_RESULT});
    dir_tab.push_back({1'b0, REQ_READ, 8'h00, 5'd25, 7'd0, NO_RESULT});
    dir_tab.push_back({1'b1, REQ_CLEAR, 8'h00, 5'd0, 7'd0,
                       5'd0, 7'd0, 11'd0, 8'h00, 8'h00, 1'b0});
    dir_tab.push_back({1'b1, REQ_READ, 8'h00, 5'd12, 7'd40,
                       5'd0, 7'd0, 11'd0, BLANK_CH, DEFAULT_ATTR, 1'b0});
    dir_tab.push_back({1'b0, REQ_READ, 8'h00, 5'd24, 7'd79, NO_RESULT});

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    // hold off until the power-up blanking pass is done
    do @(posedge clk); while (!in_ready);

    in_idle_pct = 25;
    out_idle_pct = 65;
    foreach (dir_tab[i]) send_item(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].want);

    for (s = 0; s < N_SEGS; s++) begin
      wait_for_quiet();
      if (s == 0) set_colours(4'hF, 4'hF);
      else if (s == 1) set_colours(4'h0, 4'h0);
      else set_colours(4'($urandom_range(15)), 4'($urandom_range(15)));
      if (s < 2) begin
        in_idle_pct = 25;
        out_idle_pct = 65;
      end else if (s < 4) begin
        in_idle_pct = 65;
        out_idle_pct = 25;
      end else begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end
      for (n = 0; n < SEG_ITEMS; n++) begin
        send_item(rand_request(), 1'b0, NO_RESULT);
        // drain everything now and then
        if ($urandom_range(199) == 0) wait_for_quiet();
      end
    end

    wait_for_quiet();
    $display("Ran %0d requests, %0d replies checked:", n_items, n_replies);
    $display("  %0d scrolls, %0d clears, %0d off-screen reads", n_scrolls, n_clears, n_oob);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
